### hw/rtl/smsu_pkg.sv
// shared types, codes and constants of the segmented memory stack unit
package smsu_pkg;

  localparam int MEM_BYTES_DEF = 65536;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int BASE_IDX_W = 3;
  localparam int BASE_CNT   = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_SEL = 1'd1;

  localparam logic MODE_SHIFTED = 1'b0;
  localparam logic MODE_PROT    = 1'b1;

  localparam logic [2:0] OP_READ      = 3'd0;
  localparam logic [2:0] OP_WRITE     = 3'd1;
  localparam logic [2:0] OP_PUSH      = 3'd2;
  localparam logic [2:0] OP_POP       = 3'd3;
  localparam logic [2:0] OP_SET_SP    = 3'd4;
  localparam logic [2:0] OP_LOAD_BASE = 3'd5;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_WORD = 2'd1;

  localparam logic [2:0] NB_BYTE  = 3'd1;
  localparam logic [2:0] NB_WORD  = 3'd2;
  localparam logic [2:0] NB_DWORD = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  access_size;
    logic        use_segment;
    logic [15:0] segment;
    logic [31:0] offset;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [31:0] stack_pointer;
    logic [31:0] phys_address;
    logic        out_of_bounds;
  } out_item_t;

  typedef struct packed {
    logic       rd;
    logic       wr;
    logic [2:0] nbytes;
  } mem_req_t;

endpackage

### hw/rtl/smsu_seg.sv
// segment base table and base selection for address translation
module smsu_seg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [smsu_pkg::BASE_IDX_W-1:0] wr_idx,
  input  logic [31:0] wr_data,
  input  logic        mode,
  input  logic [15:0] sel,
  output logic [31:0] base
);
  import smsu_pkg::*;

  logic [31:0] bases_r [BASE_CNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BASE_CNT; i++) begin
        bases_r[i] <= 32'd0;
      end
    end else if (wr_en) begin
      bases_r[wr_idx] <= wr_data;
    end
  end

  assign base = (mode == MODE_PROT) ? bases_r[sel[BASE_IDX_W-1:0]] : {12'd0, sel, 4'd0};

endmodule

### hw/rtl/smsu_mem.sv
// byte store in four byte-wide banks with unaligned access and clear sweep after reset
module smsu_mem #(
  parameter int MEM_BYTES = smsu_pkg::MEM_BYTES_DEF,
  localparam int ROWS  = (MEM_BYTES + 3) / 4,
  localparam int ROW_W = $clog2(ROWS),
  localparam int AW    = ROW_W + 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  smsu_pkg::mem_req_t req,
  input  logic [AW-1:0]      addr,
  input  logic [31:0]        wdata,
  output logic [31:0]        rdata,
  output logic               clr_busy
);
  import smsu_pkg::*;

  logic [1:0]       lane;
  logic [ROW_W-1:0] row0;
  logic [ROW_W-1:0] row1;
  logic [1:0]       lane_r;
  logic             clr_busy_r;
  logic [ROW_W-1:0] clr_row_r;
  logic [7:0]       rd_q_r [4];

  assign lane     = addr[1:0];
  assign row0     = addr[AW-1:2];
  assign row1     = row0 + 1'b1;
  assign clr_busy = clr_busy_r;

  // clear sweep, one row of four bytes per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_row_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_row_r == ROW_W'(ROWS - 1)) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_row_r <= clr_row_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      lane_r <= lane;
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0]       bank_mem [ROWS];
    logic [1:0]       idx;
    logic             en;
    logic [ROW_W-1:0] row_b;
    logic             we;
    logic [ROW_W-1:0] waddr;
    logic [7:0]       wd;

    assign idx   = 2'(b) - lane;
    assign en    = {1'b0, idx} < req.nbytes;
    assign row_b = (2'(b) < lane) ? row1 : row0;
    assign we    = clr_busy_r | (req.wr & en);
    assign waddr = clr_busy_r ? clr_row_r : row_b;
    assign wd    = clr_busy_r ? 8'd0 : wdata[8*idx +: 8];

    always_ff @(posedge clk) begin
      if (we) begin
        bank_mem[waddr] <= wd;
      end
      if (req.rd) begin
        rd_q_r[b] <= bank_mem[row_b];
      end
    end
  end

  always_comb begin
    logic [1:0] src;
    for (int i = 0; i < 4; i++) begin
      src = 2'(i) + lane_r;
      rdata[8*i +: 8] = rd_q_r[src];
    end
  end

endmodule

### hw/rtl/segmented_memory_stack_unit.sv
// top level of the segmented memory stack unit: sequencer, stack pointer, config, result register
// sequence: the item is registered on transfer and passes ST_XLAT, ST_MEM and ST_DATA, where it
//   waits while the result register is full and stalled; the translate add, the bank access with
//   its registered read and the byte alignment run in turn, one item at a time (taken in ST_IDLE)
// reset: the byte store is cleared one row of four bytes per cycle, with the input stalled;
//   config, bases and stack pointer reset to zero
module segmented_memory_stack_unit #(
  parameter int MEM_BYTES = smsu_pkg::MEM_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  smsu_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output smsu_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [smsu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [smsu_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import smsu_pkg::*;

  localparam int ROWS  = (MEM_BYTES + 3) / 4;
  localparam int ROW_W = $clog2(ROWS);
  localparam int AW    = ROW_W + 2;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_XLAT = 4'b0010,
    ST_MEM  = 4'b0100,
    ST_DATA = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  in_item_t    item_r;
  logic        mode_r;
  logic [15:0] stack_sel_r;
  logic [31:0] sp_r;
  logic [31:0] eff_off_r;
  logic        xlat_r;
  logic [15:0] sel_r;
  logic [2:0]  nbytes_r;
  logic [31:0] phys_r;
  logic        oob_r;
  logic        out_valid_r;
  out_item_t   out_data_r;

  logic        accept;
  logic        is_rd, is_wr, is_mem;
  logic [2:0]  step;
  logic [31:0] sp_dec;
  logic [2:0]  size_nb;
  logic [31:0] base;
  logic [32:0] end_addr;
  logic        in_rng;
  mem_req_t    mem_req;
  logic [31:0] mem_rdata;
  logic        mem_busy;
  logic [31:0] mask;
  logic        out_load;
  out_item_t   res;

  assign accept    = in_valid & ~in_stall;
  assign in_stall  = (state_r != ST_IDLE) | mem_busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_rd  = (item_r.op == OP_READ) || (item_r.op == OP_POP);
  assign is_wr  = (item_r.op == OP_WRITE) || (item_r.op == OP_PUSH);
  assign is_mem = is_rd | is_wr;
  assign step   = (mode_r == MODE_PROT) ? NB_DWORD : NB_WORD;
  assign sp_dec = sp_r - {29'd0, step};

  always_comb begin
    case (in_data.access_size)
      SZ_BYTE: size_nb = NB_BYTE;
      SZ_WORD: size_nb = NB_WORD;
      default: size_nb = NB_DWORD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_SHIFTED;
      stack_sel_r <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ADDR_MODE: mode_r <= cfg_data[0];
        CFG_STACK_SEL: stack_sel_r <= cfg_data;
        default: ;
      endcase
    end
  end

  smsu_seg u_seg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept && (in_data.op == OP_LOAD_BASE)),
    .wr_idx  (in_data.segment[BASE_IDX_W-1:0]),
    .wr_data (in_data.write_data),
    .mode    (mode_r),
    .sel     (sel_r),
    .base    (base)
  );

  // bounds check at full precision
  assign end_addr = {1'b0, phys_r} + 33'(nbytes_r - 3'd1);
  assign in_rng   = end_addr < 33'(MEM_BYTES);

  always_comb begin
    mem_req.rd     = (state_r == ST_MEM) & is_rd & in_rng;
    mem_req.wr     = (state_r == ST_MEM) & is_wr & in_rng;
    mem_req.nbytes = nbytes_r;
  end

  smsu_mem #(
    .MEM_BYTES (MEM_BYTES)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mem_req),
    .addr     (phys_r[AW-1:0]),
    .wdata    (item_r.write_data),
    .rdata    (mem_rdata),
    .clr_busy (mem_busy)
  );

  always_comb begin
    case (nbytes_r)
      NB_BYTE: mask = 32'h0000_00FF;
      NB_WORD: mask = 32'h0000_FFFF;
      default: mask = 32'hFFFF_FFFF;
    endcase
  end

  always_comb begin
    res.read_data     = is_rd ? (oob_r ? mask : (mem_rdata & mask)) : 32'd0;
    res.stack_pointer = sp_r;
    res.phys_address  = is_mem ? phys_r : 32'd0;
    res.out_of_bounds = oob_r;
  end

  assign out_load = (state_r == ST_DATA) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_XLAT;
      ST_XLAT: state_nxt = ST_MEM;
      ST_MEM:  state_nxt = ST_DATA;
      ST_DATA: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sp_r    <= 32'd0;
    end else begin
      state_r <= state_nxt;
      if (accept && (in_data.op == OP_PUSH)) begin
        sp_r <= sp_dec;
      end else if (accept && (in_data.op == OP_SET_SP)) begin
        sp_r <= in_data.write_data;
      end else if ((state_r == ST_XLAT) && (item_r.op == OP_POP)) begin
        sp_r <= sp_r + {29'd0, step};
      end
    end
  end

  // item capture and address path
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
      case (in_data.op)
        OP_PUSH: begin
          eff_off_r <= sp_dec;
          xlat_r    <= 1'b1;
          sel_r     <= stack_sel_r;
          nbytes_r  <= step;
        end
        OP_POP: begin
          eff_off_r <= sp_r;
          xlat_r    <= 1'b1;
          sel_r     <= stack_sel_r;
          nbytes_r  <= step;
        end
        default: begin
          eff_off_r <= in_data.offset;
          xlat_r    <= in_data.use_segment;
          sel_r     <= in_data.segment;
          nbytes_r  <= size_nb;
        end
      endcase
    end
    if (state_r == ST_XLAT) begin
      phys_r <= xlat_r ? (base + eff_off_r) : eff_off_r;
    end
    if (state_r == ST_MEM) begin
      oob_r <= is_mem & ~in_rng;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res;
    end
  end

  a_accept_to_xlat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_XLAT))
    else $error("transfer did not start translation");

  a_rw_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.rd && mem_req.wr))
    else $error("bank read and write issued together");

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr |=> !oob_r)
    else $error("bank write issued for out of range access");

  a_oob_ones: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && res.out_of_bounds && is_rd) |-> (res.read_data[7:0] == 8'hFF))
    else $error("out of range read not all ones");

  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    mem_busy |-> in_stall)
    else $error("input taken during clear sweep");

endmodule
